// ----- hw/rtl/kscd_pkg.sv -----
package kscd_pkg;

  // request codes carried in tuser
  typedef enum logic [3:0] {
    REQ_LOOKUP      = 4'd0,
    REQ_READ_KEY    = 4'd1,
    REQ_READ_FLAGS  = 4'd2,
    REQ_READ_AGE    = 4'd3,
    REQ_READ_VALUE  = 4'd4,
    REQ_WRITE_KEY   = 4'd5,
    REQ_UPDATE_FLAG = 4'd6,
    REQ_TOUCH_AGE   = 4'd7,
    REQ_WRITE_VALUE = 4'd8,
    REQ_RELEASE     = 4'd9
  } req_t;

  // configuration register indexes
  localparam logic [7:0] CFG_BUSY_MASK = 8'd0;
  localparam logic [7:0] CFG_AGE_GAP   = 8'd1;

  localparam logic [31:0] BUSY_MASK_RESET = 32'h8000_0000;
  localparam logic [15:0] AGE_GAP_RESET   = 16'd20;

  // one directory row
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] flags;
    logic [63:0] age;
    logic [31:0] value;
  } row_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_PREF,
    ST_SCAN,
    ST_RECOUNT,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/keyed_slot_cache_directory_core.sv -----
// keyed slot cache directory
// requests enter on the s_ group (tuser = request code, tdata = operands); one
// result per request leaves on the m_ group. configuration writes use cfg_.
// a lookup reduces the key modulo SLOTS sixteen bits at a time with a reciprocal
// multiply (an estimate step and a remainder step per digit), reads the
// preferred slot, and on a mismatch scans the row memory one slot per cycle.
// other requests read the row, write back the modified row for the write codes,
// then load the result; a bad index or an unused code skips the read and goes
// straight to the result. the next request is taken in the cycle after the
// result is loaded. the row memory has a registered read.
// a write of busy_flag_mask from the idle state sweeps all SLOTS rows to recount busy slots.
// after reset a clearing pass writes zero to every row, during which no
// request is taken; configuration writes are still taken then.
// a result sits in the output register until taken; the next request is
// accepted meanwhile, and its result waits while the receiver stalls.
module keyed_slot_cache_directory_core #(
  parameter int SLOTS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // req_type
  input  logic [3:0]    s_tuser,
  // slot_index, search_key, and_mask, or_mask, new_value, zero pad
  input  logic [175:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // hit, hit_slot, victim_found, victim_slot, previous_word, bad_index,
  // busy_slots, empty_slots, hit_total, miss_total, fast_hit_total, zero pad
  output logic [311:0]  m_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import kscd_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // floor(2^28 / SLOTS), quotient estimate is at most one short
  localparam logic [27:0] MOD_RECIP = 28'((64'd1 << 28) / SLOTS);

  row_t             mem [SLOTS];
  row_t             rdata;
  logic [IW-1:0]    rd_addr;
  logic             mem_we;
  logic [IW-1:0]    waddr;
  row_t             wdata;

  state_t           state, state_next;
  logic [3:0]       req;
  logic [IW-1:0]    idx;
  logic [63:0]      key;
  logic [31:0]      andm, orm, nval;
  logic [31:0]      busy_mask;
  logic [15:0]      age_gap;
  logic [IW-1:0]    rem, rem_next;
  logic [1:0]       mcnt;
  logic             mphase;
  logic [27:0]      quo;
  logic [63:0]      key_sh;
  logic [27:0]      mod_x, mod_r;
  logic [55:0]      mod_prod;
  logic [IW-1:0]    sc;
  logic             pref_ok;
  logic             hv;
  logic [IW-1:0]    victim;
  logic [63:0]      vage;
  logic [63:0]      age_clock, hit_cnt, miss_cnt, fast_cnt;
  logic [12:0]      busy_count, empty_count;

  logic             r_hit, r_vf, r_bad;
  logic [11:0]      r_hslot, r_vslot;
  logic [63:0]      r_prev;

  logic             in_acc, cfg_acc, out_free, idx_ok, is_lookup, row_empty, row_busy;
  logic             key_eq, take_v, last_sc, new_empty, new_busy;
  logic [IW-1:0]    pref;

  assign in_acc    = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !m_tvalid || m_tready;
  assign idx_ok    = {1'b0, s_tdata[11:0]} < 13'(SLOTS);
  assign is_lookup = (s_tuser == REQ_LOOKUP);
  assign pref      = rem;
  assign row_empty = (rdata.key == 64'd0) && (rdata.flags == 32'd0) && (rdata.age == 64'd0);
  assign row_busy  = (rdata.flags & busy_mask) != 32'd0;
  assign key_eq    = (rdata.key == key);
  assign last_sc   = (sc == IW'(SLOTS - 1));
  assign new_empty = (wdata.key == 64'd0) && (wdata.flags == 32'd0) && (wdata.age == 64'd0);
  assign new_busy  = (wdata.flags & busy_mask) != 32'd0;

  // victim rule for the slot under scan
  assign take_v = !row_busy && (!hv || (pref_ok && sc == pref) || rdata.age < vage) &&
                  !(pref_ok && hv && victim == pref);

  // one sixteen-bit digit of the key reduction, most significant digit first
  assign key_sh   = key >> {mcnt, 4'd0};
  assign mod_x    = 28'({rem, key_sh[15:0]});
  assign mod_prod = mod_x * MOD_RECIP;
  assign mod_r    = mod_x - quo * 28'(SLOTS);
  assign rem_next = (mod_r >= 28'(SLOTS)) ? IW'(mod_r - 28'(SLOTS)) : IW'(mod_r);

  // row memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (sc == IW'(SLOTS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (is_lookup) state_next = ST_MOD;
          else if (s_tuser <= REQ_RELEASE && idx_ok) state_next = ST_PREF;
          else state_next = ST_DONE;
        end else if (cfg_acc && cfg_index == CFG_BUSY_MASK) begin
          state_next = ST_RECOUNT;
        end
      end
      ST_MOD:     if (mphase && mcnt == 2'd0) state_next = ST_PREF;
      ST_PREF: begin
        if (req == REQ_LOOKUP && !key_eq) state_next = ST_SCAN;
        else state_next = ST_DONE;
      end
      ST_SCAN:    if (key_eq || last_sc) state_next = ST_DONE;
      ST_RECOUNT: if (last_sc) state_next = ST_IDLE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // handshakes, memory addresses and the modified row
  always_comb begin
    s_tready  = (state == ST_IDLE);
    cfg_ready = (state == ST_CLEAR) || (state == ST_IDLE && !s_tvalid);
    mem_we    = 1'b0;
    waddr     = idx;
    wdata     = rdata;
    rd_addr   = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = sc;
        wdata  = '0;
      end
      // slot of the request, or row zero ahead of a recount
      ST_IDLE:    rd_addr = s_tvalid ? s_tdata[IW-1:0] : '0;
      ST_MOD:     rd_addr = rem_next;
      ST_SCAN,
      ST_RECOUNT: rd_addr = sc + 1'b1;
      ST_PREF: begin
        case (req)
          REQ_WRITE_KEY: begin
            mem_we    = 1'b1;
            wdata.key = key;
          end
          REQ_UPDATE_FLAG: begin
            mem_we      = 1'b1;
            wdata.flags = (rdata.flags & andm) | orm;
          end
          REQ_TOUCH_AGE: begin
            mem_we    = 1'b1;
            wdata.age = age_clock + 64'd1;
          end
          REQ_WRITE_VALUE: begin
            mem_we      = 1'b1;
            wdata.value = nval;
          end
          REQ_RELEASE: begin
            mem_we = 1'b1;
            wdata  = '0;
          end
          default: mem_we = 1'b0;
        endcase
      end
      default: rd_addr = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      sc          <= '0;
      busy_mask   <= BUSY_MASK_RESET;
      age_gap     <= AGE_GAP_RESET;
      age_clock   <= '0;
      hit_cnt     <= '0;
      miss_cnt    <= '0;
      fast_cnt    <= '0;
      busy_count  <= '0;
      empty_count <= 13'(SLOTS);
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_CLEAR: sc <= sc + 1'b1;
        ST_IDLE:  sc <= '0;
        ST_PREF: begin
          sc <= '0;
          if (req == REQ_LOOKUP) begin
            if (key_eq) begin
              if (row_empty) miss_cnt <= miss_cnt + 64'd1;
              else begin
                hit_cnt  <= hit_cnt + 64'd1;
                fast_cnt <= fast_cnt + 64'd1;
              end
            end
          end else begin
            if (req == REQ_TOUCH_AGE) age_clock <= age_clock + 64'd1;
            if (mem_we) begin
              if (row_empty && !new_empty) empty_count <= empty_count - 13'd1;
              else if (!row_empty && new_empty) empty_count <= empty_count + 13'd1;
              if (row_busy && !new_busy) busy_count <= busy_count - 13'd1;
              else if (!row_busy && new_busy) busy_count <= busy_count + 13'd1;
            end
          end
        end
        ST_SCAN: begin
          sc <= sc + 1'b1;
          if (key_eq && !row_empty) hit_cnt <= hit_cnt + 64'd1;
          else if (key_eq || last_sc) miss_cnt <= miss_cnt + 64'd1;
        end
        ST_RECOUNT: begin
          sc <= sc + 1'b1;
          if (row_busy) busy_count <= busy_count + 13'd1;
        end
        default: sc <= sc;
      endcase
      // configuration writes
      if (cfg_acc) begin
        if (cfg_index == CFG_BUSY_MASK) begin
          busy_mask  <= cfg_data;
          busy_count <= '0;
        end else if (cfg_index == CFG_AGE_GAP) begin
          age_gap <= cfg_data[15:0];
        end
      end
    end
  end

  // request payload and result fields
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          req     <= s_tuser;
          idx     <= s_tdata[IW-1:0];
          key     <= s_tdata[75:12];
          andm    <= s_tdata[107:76];
          orm     <= s_tdata[139:108];
          nval    <= s_tdata[171:140];
          rem     <= '0;
          mcnt    <= 2'd3;
          mphase  <= 1'b0;
          hv      <= 1'b0;
          r_hit   <= 1'b0;
          r_hslot <= '0;
          r_vf    <= 1'b0;
          r_vslot <= '0;
          r_bad   <= !is_lookup && s_tuser <= REQ_RELEASE && !idx_ok;
          r_prev  <= (!is_lookup && s_tuser <= REQ_RELEASE && !idx_ok) ? '1 : '0;
        end
      end
      // quotient estimate, then remainder with one correction
      ST_MOD: begin
        if (!mphase) begin
          quo    <= mod_prod[55:28];
          mphase <= 1'b1;
        end else begin
          rem    <= rem_next;
          mcnt   <= mcnt - 2'd1;
          mphase <= 1'b0;
        end
      end
      ST_PREF: begin
        pref_ok <= !row_busy && (age_clock - rdata.age) >= {48'd0, age_gap};
        if (req == REQ_LOOKUP) begin
          if (key_eq) begin
            if (row_empty) begin
              r_vf    <= 1'b1;
              r_vslot <= 12'(pref);
            end else begin
              r_hit   <= 1'b1;
              r_hslot <= 12'(pref);
            end
          end
        end else begin
          case (req)
            REQ_READ_KEY,
            REQ_WRITE_KEY:   r_prev <= rdata.key;
            REQ_READ_FLAGS,
            REQ_UPDATE_FLAG: r_prev <= {32'd0, rdata.flags};
            REQ_READ_AGE,
            REQ_TOUCH_AGE:   r_prev <= rdata.age;
            REQ_READ_VALUE,
            REQ_WRITE_VALUE: r_prev <= {32'd0, rdata.value};
            default:         r_prev <= '0;
          endcase
        end
      end
      ST_SCAN: begin
        if (key_eq) begin
          if (row_empty) begin
            r_vf    <= 1'b1;
            r_vslot <= hv ? 12'(victim) : 12'(sc);
          end else begin
            r_hit   <= 1'b1;
            r_hslot <= 12'(sc);
            r_vf    <= hv;
            r_vslot <= hv ? 12'(victim) : '0;
          end
        end else begin
          if (take_v) begin
            hv     <= 1'b1;
            victim <= sc;
            vage   <= rdata.age;
          end
          if (last_sc) begin
            r_vf    <= hv || take_v;
            r_vslot <= take_v ? 12'(sc) : (hv ? 12'(victim) : '0);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {3'd0, fast_cnt, miss_cnt, hit_cnt, empty_count, busy_count,
                      r_bad, r_prev, r_vslot, r_vf, r_hslot, r_hit};
        end
      end
      default: rem <= rem;
    endcase
  end

  // checks
  a_empty_range: assert property (@(posedge clk) disable iff (rst)
    empty_count <= 13'(SLOTS)) else $error("empty count above slot count");
  a_busy_range: assert property (@(posedge clk) disable iff (rst)
    busy_count <= 13'(SLOTS)) else $error("busy count above slot count");
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_RECOUNT) |-> !mem_we)
    else $error("row write during scan");
  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> m_tvalid)
    else $error("result not presented");

endmodule
